@@ rtl/stli_pkg.sv @@
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants for the sorted-table interpolator
// Beat structs for the item and result channels, status and function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stli_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned DataWidthDef  = 32;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned CntW          = 11;
  localparam int unsigned StatW         = 3;
  localparam int unsigned FracBits      = 16;

  localparam logic [0:0] FuncLoad  = 1'b0;
  localparam logic [0:0] FuncQuery = 1'b1;

  localparam logic [StatW-1:0] StInside = 3'd0;
  localparam logic [StatW-1:0] StBelow  = 3'd1;
  localparam logic [StatW-1:0] StAbove  = 3'd2;
  localparam logic [StatW-1:0] StZero   = 3'd3;
  localparam logic [StatW-1:0] StSat    = 3'd4;

  typedef struct packed {
    logic [0:0]         func;
    logic [IdxW-1:0]    entry_index;
    logic signed [31:0] entry_time;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_time;
    logic               last_in_batch;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic signed [31:0] slope;
    logic [IdxW-1:0]    segment_index;
    logic [StatW-1:0]   status;
    logic               batch_end;
  } out_beat_t;

endpackage

`default_nettype wire

@@ rtl/stli_ram.sv @@
// ----------------------------------------------------------------------------
// stli_ram: generic single-port RAM
// One address per cycle, read every cycle and written on we_i; registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

@@ rtl/stli_div.sv @@
// ----------------------------------------------------------------------------
// stli_div: radix-2 signed divider
// Quotient of a 64-bit dividend by a 33-bit divisor, truncated toward zero,
// one quotient bit per cycle. The full 65-bit signed quotient is returned;
// the caller checks it against the 32-bit result range.
// ----------------------------------------------------------------------------
`default_nettype none

module stli_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] dividend_i,
  input  wire logic signed [32:0] divisor_i,
  output logic                    done_o,
  output logic signed [64:0]      quot_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] dsr_q, dsr_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  // one restoring step
  always_comb begin
    shifted = {rem_q[62:0], quo_q[63]};
    trial   = {1'b0, shifted} - {32'd0, dsr_q};
    rem_d = rem_q; quo_d = quo_q; dsr_d = dsr_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
      dsr_d  = divisor_i[32] ? 33'(-divisor_i) : 33'(divisor_i);
      neg_d  = dividend_i[63] ^ divisor_i[32];
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

`default_nettype wire

@@ rtl/sorted_table_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: knot table with interpolating lookup
// Loads (time, value) knots; a query binary-searches the table, then
// computes the Q16.16 segment slope and the interpolated value with saturation.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  --------+-----------+--------------------------------------
//  item    | in        | in_valid_i / in_ready_o / in_data_i
//  result  | out       | out_valid_o / out_ready_i / out_data_o
//  config  | in        | cfg_valid_i / cfg_ready_o / cfg_data_i
//
// A load beat returns to idle through S_OUT with no result. A query runs
// S_PROBE, S_PWAIT, S_PCMP per probe (log2(depth)+1 probes at most), leaves
// the search, reads four knots and, unless the segment has zero width, divides
// for the slope and forms the product before the result. Reset returns
// entries_in_use to 2; table contents are undefined until loaded. A held
// result stalls the next item until taken.
`default_nettype none

module sorted_table_linear_interpolator
  import stli_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire in_beat_t     in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output out_beat_t         out_data_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [CntW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned SW = AW + 2;  // signed search bounds

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_PWAIT, S_PCMP, S_RD, S_DIV, S_MUL, S_MUL2, S_OUT
  } state_e;

  state_e state_q;
  logic [CntW-1:0] n_cfg_q;
  in_beat_t item_q;
  logic signed [SW-1:0] lo_q, hi_q, mid_q;
  logic [AW-1:0] addr_q;
  logic          we_q;
  logic [2:0]    rstep_q;
  logic signed [31:0] t0_q, t1_q, y0_q, y1_q, tf_q, tl_q;
  logic signed [31:0] slope_q;
  logic          sat_q;
  logic signed [63:0] prod_q;
  logic [AW-1:0] seg_q;
  logic [AW:0]   n_eff;
  logic [31:0]   t_rd, v_rd;
  logic          div_start_q, div_done;
  logic signed [64:0] div_quot;
  logic signed [32:0] dt;
  logic signed [63:0] dividend;

  // clamp entries_in_use to [2, depth]
  always_comb begin
    if (n_cfg_q < CntW'(2)) n_eff = (AW+1)'(2);
    else if ({{(32-CntW){1'b0}}, n_cfg_q} > 32'(TableDepth)) n_eff = (AW+1)'(TableDepth);
    else n_eff = (AW+1)'(n_cfg_q);
  end

  stli_ram #(.Width(32), .Depth(TableDepth)) u_times (
    .clk_i, .we_i(we_q), .addr_i(addr_q), .wdata_i(item_q.entry_time), .rdata_o(t_rd)
  );
  stli_ram #(.Width(32), .Depth(TableDepth)) u_values (
    .clk_i, .we_i(we_q), .addr_i(addr_q), .wdata_i(item_q.entry_value), .rdata_o(v_rd)
  );

  assign dt       = 33'(t1_q) - 33'(t0_q);
  assign dividend = (64'(y1_q) - 64'(y0_q)) <<< FracBits;

  stli_div u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .dividend_i(dividend),
    .divisor_i(dt), .done_o(div_done), .quot_o(div_quot)
  );

  logic signed [SW-1:0] seg_s;
  logic signed [63:0] val_full;
  logic signed [32:0] dq;

  always_comb begin
    seg_s = (lo_q > 0) ? lo_q - SW'(1) : '0;
    if (seg_s > $signed({1'b0, n_eff}) - SW'(2)) seg_s = $signed({1'b0, n_eff}) - SW'(2);
    dq = 33'(item_q.query_time) - 33'(t0_q);
    val_full = 64'(y0_q) + (prod_q >>> FracBits);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_cfg_q     <= CntW'(2);
      out_valid_o <= 1'b0;
      we_q        <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      we_q        <= 1'b0;
      div_start_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) n_cfg_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.func == FuncLoad) begin
              // loads past the table end are dropped
              we_q   <= (32'(in_data_i.entry_index) < TableDepth);
              addr_q <= AW'(in_data_i.entry_index);
              state_q <= S_OUT;
            end else begin
              lo_q <= '0;
              hi_q <= $signed({1'b0, n_eff}) - SW'(1);
              state_q <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (lo_q <= hi_q) begin
            mid_q  <= (lo_q + hi_q) >>> 1;
            addr_q <= AW'((lo_q + hi_q) >>> 1);
            state_q <= S_PWAIT;
          end else begin
            seg_q   <= AW'(seg_s);
            addr_q  <= AW'(seg_s);
            rstep_q <= 3'd0;
            state_q <= S_RD;
          end
        end
        S_PWAIT: state_q <= S_PCMP;
        S_PCMP: begin
          if ($signed(t_rd) < item_q.query_time) lo_q <= mid_q + SW'(1);
          else hi_q <= mid_q - SW'(1);
          state_q <= S_PROBE;
        end
        // read seg, seg+1, 0, n-1; data lands behind the address and RAM read registers
        S_RD: begin
          rstep_q <= rstep_q + 3'd1;
          case (rstep_q)
            3'd0: addr_q <= seg_q + AW'(1);
            3'd1: addr_q <= '0;
            3'd2: addr_q <= AW'(n_eff - (AW+1)'(1));
            default: ;
          endcase
          case (rstep_q)
            3'd1: begin t0_q <= t_rd; y0_q <= v_rd; end
            3'd2: begin t1_q <= t_rd; y1_q <= v_rd; end
            3'd3: tf_q <= t_rd;
            3'd4: begin
              tl_q <= t_rd;
              if (t1_q == t0_q) begin
                state_q <= S_OUT;
              end else begin
                div_start_q <= 1'b1;
                state_q <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            if (div_quot > 65'sh7FFFFFFF) begin
              slope_q <= 32'sh7FFFFFFF; sat_q <= 1'b1;
            end else if (div_quot < -65'sh80000000) begin
              slope_q <= -32'sh80000000; sat_q <= 1'b1;
            end else begin
              slope_q <= div_quot[31:0]; sat_q <= 1'b0;
            end
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= 64'(slope_q) * 64'(dq);
          state_q <= S_MUL2;
        end
        S_MUL2: state_q <= S_OUT;
        S_OUT: begin
          if (item_q.func == FuncLoad) begin
            state_q <= S_IDLE;
          end else if (!out_valid_o) begin
            out_data_o.segment_index <= IdxW'(seg_q);
            out_data_o.batch_end     <= item_q.last_in_batch;
            if (t1_q == t0_q) begin
              out_data_o.interp_value <= y0_q;
              out_data_o.slope        <= '0;
              out_data_o.status       <= StZero;
            end else begin
              out_data_o.slope <= slope_q;
              if (val_full > 64'sh7FFFFFFF) out_data_o.interp_value <= 32'sh7FFFFFFF;
              else if (val_full < -64'sh80000000) out_data_o.interp_value <= -32'sh80000000;
              else out_data_o.interp_value <= val_full[31:0];
              if (sat_q || val_full > 64'sh7FFFFFFF || val_full < -64'sh80000000)
                out_data_o.status <= StSat;
              else if (item_q.query_time < tf_q) out_data_o.status <= StBelow;
              else if (item_q.query_time > tl_q) out_data_o.status <= StAbove;
              else out_data_o.status <= StInside;
            end
            out_valid_o <= 1'b1;
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
  end

endmodule

`default_nettype wire

@@ rtl/stli_checker.sv @@
// ----------------------------------------------------------------------------
// stli_checker: port-level checks for the interpolator
// Handshake stability and result field sanity.
// ----------------------------------------------------------------------------
`default_nettype none

module stli_checker
  import stli_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_data_o,
  input wire logic      cfg_ready_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // no item taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item accepted with result pending");

  // config and item ready move together
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == in_ready_o)
    else $error("config ready mismatch");

  // zero-width segment reports zero slope
  a_zero_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StZero |-> out_data_o.slope == '0)
    else $error("zero-width segment with nonzero slope");

  // ready is low in the cycle after an item is accepted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held across accepted item");

endmodule

bind sorted_table_linear_interpolator stli_checker u_stli_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_data_o, .cfg_ready_o
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_table_linear_interpolator
// Loads knot tables of varied shape and size, queries them in and around range,
// and checks each result against a hand-written value or a Q16.16 predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stli_pkg::*;

  // Directed vector: a load or a query, optionally with a hand-written result
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } dir_vec_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_beat_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_beat_t       out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CntW-1:0] cfg_data_i = '0;

  // predictor state
  logic signed [31:0] knot_time [1024];
  logic signed [31:0] knot_val  [1024];
  logic [CntW-1:0]    knots_cfg = CntW'(2);
  out_beat_t          pending_results [$];

  int err_cnt = 0;
  int n_items = 0;
  int n_queries = 0;
  int n_loads = 0;
  int n_cfg = 0;
  int n_results = 0;
  int st_hist [8];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rcv_hold = 0;

  always #5 clk_i = ~clk_i;

  sorted_table_linear_interpolator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic longint clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Binary search for the segment, then Q16.16 slope and value
  function automatic out_beat_t interpolate(logic signed [31:0] q, logic last);
    int        n, lo, hi, mid, seg;
    longint    t0, t1, y0, y1, dt, dy, slp, val;
    bit        sat;
    out_beat_t r;
    n = int'(knots_cfg);
    if (n < 2) n = 2;
    if (n > 1024) n = 1024;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (knot_time[mid] < q) lo = mid + 1;
      else hi = mid - 1;
    end
    seg = (lo > 0) ? lo - 1 : 0;
    if (seg > n - 2) seg = n - 2;
    t0 = knot_time[seg];
    t1 = knot_time[seg+1];
    y0 = knot_val[seg];
    y1 = knot_val[seg+1];
    dt = t1 - t0;
    dy = y1 - y0;
    sat = 1'b0;
    slp = 0;
    val = y0;
    if (dt == 0) begin
      r.status = StZero;
    end else begin
      slp = clamp32((dy * 64'sd65536) / dt, sat);
      // arithmetic shift gives the floor of the Q16.16 product
      val = clamp32(y0 + ((slp * (longint'(q) - t0)) >>> 16), sat);
      if (sat) r.status = StSat;
      else if (q < knot_time[0]) r.status = StBelow;
      else if (q > knot_time[n-1]) r.status = StAbove;
      else r.status = StInside;
    end
    r.interp_value = val[31:0];
    r.slope = slp[31:0];
    r.segment_index = seg[IdxW-1:0];
    r.batch_end = last;
    return r;
  endfunction

  // Offer one item beat; update predictor when accepted
  task automatic send_beat(in_beat_t b, bit typed, out_beat_t res);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (b.func == FuncLoad) begin
      knot_time[b.entry_index] = b.entry_time;
      knot_val[b.entry_index] = b.entry_value;
      n_loads++;
    end else begin
      pending_results.push_back(typed ? res : interpolate(b.query_time, b.last_in_batch));
      n_queries++;
    end
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.func = 1'($urandom());
    b.entry_index = IdxW'($urandom());
    b.entry_time = $urandom();
    b.entry_value = $urandom();
    b.query_time = $urandom();
    b.last_in_batch = 1'($urandom());
    return b;
  endfunction

  task automatic load_knot(int idx, logic signed [31:0] t, logic signed [31:0] v);
    in_beat_t b;
    b = rand_beat();
    b.func = FuncLoad;
    b.entry_index = IdxW'(idx);
    b.entry_time = t;
    b.entry_value = v;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic query_at(logic signed [31:0] q);
    in_beat_t b;
    b = rand_beat();
    b.func = FuncQuery;
    b.query_time = q;
    send_beat(b, 1'b0, '0);
  endtask

  // Register write only with the block drained and past its load latency
  task automatic write_knot_count(logic [CntW-1:0] val);
    drop_valid();
    wait (pending_results.size() == 0);
    repeat (150) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    knots_cfg = val;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result stall: random, or held off for a long stretch on request
  always @(negedge clk_i) begin
    if (rcv_hold > 0) begin
      out_ready_i <= 1'b0;
      rcv_hold <= rcv_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_beat_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        w = pending_results.pop_front();
        n_results++;
        st_hist[w.status]++;
        if (out_data_o.interp_value !== w.interp_value)
          report_mismatch("interp_value", out_data_o.interp_value, w.interp_value);
        if (out_data_o.slope !== w.slope)
          report_mismatch("slope", out_data_o.slope, w.slope);
        if (out_data_o.segment_index !== w.segment_index)
          report_mismatch("segment_index", out_data_o.segment_index, w.segment_index);
        if (out_data_o.status !== w.status)
          report_mismatch("status", out_data_o.status, w.status);
        if (out_data_o.batch_end !== w.batch_end)
          report_mismatch("batch_end", out_data_o.batch_end, w.batch_end);
      end
    end
  end

  // Load a table of n knots of some shape if asked, then query it with random reloads
  task automatic run_table(int n, bit do_load, int nq, bit pressure);
    longint tt [1024];
    longint tmin, tmax, t, span, ql;
    int     shape, r, i;
    shape = $urandom_range(9);
    t = longint'($signed($urandom_range(65535))) - 32768;
    if (do_load) begin
      for (i = 0; i < n; i++) begin
        if (shape == 0) begin
          tt[i] = $signed($urandom());                  // unsorted
        end else if (shape == 1) begin
          tt[i] = -64'sd2147483648 + (longint'(i) * 64'sd4294967295) / (n - 1);
        end else begin
          if ($urandom_range(9) != 0) t += $urandom_range(1 << $urandom_range(20));
          if (t > 64'sd2147483647) t = 64'sd2147483647;
          tt[i] = t;
        end
        load_knot(i, 32'(tt[i]),
                  (shape == 1 || $urandom_range(9) == 0) ? $urandom()
                                                         : 32'($urandom_range(1 << 25)) - 32'(1 << 24));
      end
    end else begin
      for (i = 0; i < n; i++) tt[i] = knot_time[i];
    end
    tmin = tt[0];
    tmax = tt[0];
    for (i = 1; i < n; i++) begin
      if (tt[i] < tmin) tmin = tt[i];
      if (tt[i] > tmax) tmax = tt[i];
    end
    span = (tmax - tmin) / 4 + 16;
    for (i = 0; i < nq; i++) begin
      if (pressure && i == nq / 3) rcv_hold = 500;
      if (pressure && i == 2 * nq / 3) begin
        drop_valid();
        wait (pending_results.size() == 0);
      end
      r = $urandom_range(99);
      if (r < 8) begin
        load_knot($urandom_range(n - 1), 32'(tt[$urandom_range(n - 1)]), $urandom());
      end else if (r < 12) begin
        load_knot($urandom_range(1023), $urandom(), $urandom());
      end else begin
        if (r < 60) ql = tmin - span + longint'($urandom()) % (tmax - tmin + 2 * span + 1);
        else if (r < 78) ql = tt[$urandom_range(n - 1)] + $signed($urandom_range(2)) - 1;
        else if (r < 92) ql = $signed($urandom());
        else ql = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        if (ql > 64'sd2147483647) ql = 64'sd2147483647;
        if (ql < -64'sd2147483648) ql = -64'sd2147483648;
        query_at(32'(ql));
      end
    end
  endtask

  function automatic dir_vec_t d_load(int idx, logic [31:0] t, logic [31:0] v);
    dir_vec_t d;
    d.beat = '{func: FuncLoad, entry_index: IdxW'(idx), entry_time: t, entry_value: v,
               query_time: 32'h5a5a_a5a5, last_in_batch: 1'b1};
    d.typed = 1'b0;
    d.res = '0;
    return d;
  endfunction

  function automatic dir_vec_t d_query(logic [31:0] q, logic last, bit typed,
                                       logic [31:0] xv, logic [31:0] xs, logic [2:0] xst);
    dir_vec_t d;
    d.beat = '{func: FuncQuery, entry_index: IdxW'(10'h3ff), entry_time: 32'hffff_ffff,
               entry_value: 32'h0, query_time: q, last_in_batch: last};
    d.typed = typed;
    d.res = '{interp_value: xv, slope: xs, segment_index: '0, status: xst, batch_end: last};
    return d;
  endfunction

  // Run limit
  initial begin
    #40ms;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    dir_vec_t dir_tab [$];
    int       k, target, n;
    logic [CntW-1:0] cv;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two-knot table after reset (entries_in_use resets to 2)
    dir_tab.push_back(d_load(0, 32'h0, 32'h0));
    dir_tab.push_back(d_load(1, 32'h1_0000, 32'h1_0000));
    dir_tab.push_back(d_query(32'h8000, 1, 1, 32'h8000, 32'h1_0000, StInside));
    dir_tab.push_back(d_query(-32'sh1_0000, 0, 1, -32'sh1_0000, 32'h1_0000, StBelow));
    dir_tab.push_back(d_query(32'h3_0000, 0, 1, 32'h3_0000, 32'h1_0000, StAbove));
    dir_tab.push_back(d_query(32'h0, 1, 1, 32'h0, 32'h1_0000, StInside));
    // zero-width segment
    dir_tab.push_back(d_load(1, 32'h0, 32'h5));
    dir_tab.push_back(d_query(32'd123, 0, 1, 32'h0, 32'h0, StZero));
    // full-range knots: slope exactly one
    dir_tab.push_back(d_load(0, 32'h8000_0000, 32'h8000_0000));
    dir_tab.push_back(d_load(1, 32'h7fff_ffff, 32'h7fff_ffff));
    dir_tab.push_back(d_query(32'h0, 0, 1, 32'h0, 32'h1_0000, StInside));
    dir_tab.push_back(d_query(32'h7fff_ffff, 1, 1, 32'h7fff_ffff, 32'h1_0000, StInside));
    dir_tab.push_back(d_query(32'h8000_0000, 0, 1, 32'h8000_0000, 32'h1_0000, StInside));
    // slope saturation both ways
    dir_tab.push_back(d_load(0, 32'h0, 32'h0));
    dir_tab.push_back(d_load(1, 32'h1, 32'h7fff_ffff));
    dir_tab.push_back(d_query(32'h0, 0, 1, 32'h0, 32'h7fff_ffff, StSat));
    dir_tab.push_back(d_load(1, 32'h1, 32'h8000_0000));
    dir_tab.push_back(d_query(32'h0, 1, 1, 32'h0, 32'h8000_0000, StSat));
    dir_tab.push_back(d_query(32'h7fff_ffff, 0, 0, '0, '0, StInside));
    // product rounds toward minus infinity
    dir_tab.push_back(d_load(1, 32'h1_0000, 32'h1));
    dir_tab.push_back(d_query(32'hffff_ffff, 0, 1, 32'hffff_ffff, 32'h1, StBelow));
    // unsorted knots, top index
    dir_tab.push_back(d_load(0, 32'd100, 32'h7fff_0000));
    dir_tab.push_back(d_load(1, -32'sd100, 32'h8001_0000));
    dir_tab.push_back(d_query(32'h0, 1, 0, '0, '0, StInside));
    dir_tab.push_back(d_load(1023, 32'h7fff_ffff, 32'h8000_0000));
    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].res);

    // Random: three stall profiles
    k = 0;
    target = 0;
    for (int mode = 0; mode < 3; mode++) begin
      snd_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 52 : 0;
      rcv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 12 : 0;
      target += (mode == 0) ? 1100 : 350;
      while (n_items < target) begin
        case (k)
          0: cv = CntW'(2047);            // clamps to full depth
          1: cv = CntW'(0);               // clamps to two knots
          2: cv = CntW'(1024);
          3: cv = CntW'(2);
          default: cv = ($urandom_range(9) == 0) ? CntW'($urandom_range(2, 200))
                                                 : CntW'($urandom_range(2, 40));
        endcase
        write_knot_count(cv);
        n = int'(cv);
        if (n < 2) n = 2;
        if (n > 1024) n = 1024;
        run_table(n, k != 2, $urandom_range(25, 70), k == 1 || k == 5 || (k % 9 == 0));
        k++;
      end
    end

    drop_valid();
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d loads, %0d queries, %0d checked results, %0d register writes",
             n_loads, n_queries, n_results, n_cfg);
    $display("status mix: inside %0d below %0d above %0d zero-width %0d saturated %0d",
             st_hist[StInside], st_hist[StBelow], st_hist[StAbove], st_hist[StZero],
             st_hist[StSat]);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/stli_pkg.sv
rtl/stli_ram.sv
rtl/stli_div.sv
rtl/sorted_table_linear_interpolator.sv
rtl/stli_checker.sv
tb/tb_top.sv
